// File: sv/rpm_pkg.sv
package rpm_pkg;

	localparam int CORDIC_STAGES = 24;
	localparam int FRAC_BITS = 16;
	localparam int GUARD_BITS = 8;
	localparam int DW = 44;
	localparam int MAX_STAGES = 32;
	localparam logic [31:0] INV_GAIN_SQ_Q32 = 32'd1583795506;
	localparam logic [31:0] HALF_TURN = 32'h8000_0000;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	typedef logic signed [DW-1:0] coord_t;

	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		begin
			unique case (i)
				0: r = 32'h20000000;
				1: r = 32'h12E4051E;
				2: r = 32'h09FB385B;
				3: r = 32'h051111D4;
				4: r = 32'h028B0D43;
				5: r = 32'h0145D7E1;
				6: r = 32'h00A2F61E;
				7: r = 32'h00517C55;
				8: r = 32'h0028BE53;
				9: r = 32'h00145F2F;
				10: r = 32'h000A2F98;
				11: r = 32'h000517CC;
				12: r = 32'h00028BE6;
				13: r = 32'h000145F3;
				14: r = 32'h0000A2FA;
				15: r = 32'h0000517D;
				16: r = 32'h000028BE;
				17: r = 32'h0000145F;
				18: r = 32'h00000A30;
				19: r = 32'h00000518;
				20: r = 32'h0000028C;
				21: r = 32'h00000146;
				22: r = 32'h000000A3;
				23: r = 32'h00000051;
				24: r = 32'h00000029;
				25: r = 32'h00000014;
				26: r = 32'h0000000A;
				27: r = 32'h00000005;
				28: r = 32'h00000003;
				29: r = 32'h00000001;
				30: r = 32'h00000001;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

endpackage

// File: sv/rotated_pair_midpoint.sv
// Channel  | Ports                                          | Handshake
// input    | point_a/b_x/y, center_x/y, delta_angle         | start & !busy
// result   | dest_x, dest_y, saturated                      | done, one cycle
// One item may enter every cycle; busy stays low.
// An item travels through the angle conversion, the two CORDIC pipelines in each
// lane, the gain multiplier and the merge register, and done flags its result.
// Reset clears only the valid line of the pipeline; results cannot be held off.
module rotated_pair_midpoint #(
	parameter int CORDIC_STAGES = rpm_pkg::CORDIC_STAGES,
	parameter int FRAC_BITS = rpm_pkg::FRAC_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [31:0] point_a_x,
	input logic signed [31:0] point_a_y,
	input logic signed [31:0] point_b_x,
	input logic signed [31:0] point_b_y,
	input logic signed [31:0] center_x,
	input logic signed [31:0] center_y,
	input logic signed [25:0] delta_angle,
	output logic done,
	output logic signed [31:0] dest_x,
	output logic signed [31:0] dest_y,
	output logic saturated
);
	localparam int N = (CORDIC_STAGES > rpm_pkg::MAX_STAGES) ?
		rpm_pkg::MAX_STAGES : CORDIC_STAGES;
	localparam int LAT = 2 * N + 8;
	localparam int SH = 32 - FRAC_BITS;
	localparam logic [31:0] RECIP = 32'd3054198967; // ceil(2^37/45) = ceil(2^40/360)

	logic [LAT-1:0] vld_q;
	logic signed [31:0] cx_s [LAT-1];
	logic signed [31:0] cy_s [LAT-1];

	// With |delta| = 45*h + l, |delta| * 2^SH = 360 * h * 2^(SH-3) + l * 2^SH,
	// so only the small remainder term needs a division.
	logic [25:0] amag;
	logic [57:0] hprod;
	logic [25:0] lfull;
	logic [31:0] v;
	logic [63:0] fprod;
	logic [31:0] qv;
	logic neg_s1, neg_s2;
	logic [25:0] a_s1;
	logic [20:0] h_s1, h_s2;
	logic [5:0] l_s2;
	logic [31:0] d_s3;

	always_comb begin
		amag = delta_angle[25] ? 26'(-delta_angle) : 26'(delta_angle);
		hprod = 58'(amag) * 58'(RECIP);
		lfull = a_s1 - 26'(h_s1) * 26'd45;
		v = (32'(l_s2) << SH) + 32'd180;
		fprod = 64'(v) * 64'(RECIP);
		qv = (32'(h_s2) << (SH - 3)) + 32'(fprod[63:40]);
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= delta_angle[25];
		a_s1 <= amag;
		h_s1 <= hprod[57:37];
		neg_s2 <= neg_s1;
		h_s2 <= h_s1;
		l_s2 <= lfull[5:0];
		d_s3 <= neg_s2 ? -qv : qv;
		cx_s[0] <= center_x;
		cy_s[0] <= center_y;
		for (int i = 1; i < LAT - 1; i++) begin
			cx_s[i] <= cx_s[i-1];
			cy_s[i] <= cy_s[i-1];
		end
	end

	logic signed [32:0] oax_s1, oay_s1, obx_s1, oby_s1;
	logic signed [32:0] oax_s2, oay_s2, obx_s2, oby_s2;
	logic signed [32:0] oax_s3, oay_s3, obx_s3, oby_s3;
	always_ff @(posedge clk) begin
		oax_s1 <= 33'(point_a_x) - 33'(center_x);
		oay_s1 <= 33'(point_a_y) - 33'(center_y);
		obx_s1 <= 33'(point_b_x) - 33'(center_x);
		oby_s1 <= 33'(point_b_y) - 33'(center_y);
		oax_s2 <= oax_s1;
		oay_s2 <= oay_s1;
		obx_s2 <= obx_s1;
		oby_s2 <= oby_s1;
		oax_s3 <= oax_s2;
		oay_s3 <= oay_s2;
		obx_s3 <= obx_s2;
		oby_s3 <= oby_s2;
	end

	rpm_pkg::coord_t lax, lay, lbx, lby, gax, gay, gbx, gby;

	rpm_lane #(.STAGES(N)) u_lane_a (.clk, .en(1'b1), .off_x(oax_s3),
		.off_y(oay_s3), .delta(d_s3), .out_x(lax), .out_y(lay));
	rpm_lane #(.STAGES(N)) u_lane_b (.clk, .en(1'b1), .off_x(obx_s3),
		.off_y(oby_s3), .delta(d_s3), .out_x(lbx), .out_y(lby));

	rpm_gain u_gax (.clk, .en(1'b1), .v(lax), .p(gax));
	rpm_gain u_gay (.clk, .en(1'b1), .v(lay), .p(gay));
	rpm_gain u_gbx (.clk, .en(1'b1), .v(lbx), .p(gbx));
	rpm_gain u_gby (.clk, .en(1'b1), .v(lby), .p(gby));

	rpm_merge u_merge (.clk, .en(1'b1), .cx(cx_s[LAT-2]), .cy(cy_s[LAT-2]),
		.ax(gax), .ay(gay), .bx(gbx), .by(gby),
		.dx(dest_x), .dy(dest_y), .sat(saturated));

	assign done = vld_q[LAT-1];
endmodule

// File: sv/rpm_lane.sv
module rpm_lane #(
	parameter int STAGES = rpm_pkg::CORDIC_STAGES
) (
	input logic clk,
	input logic en,
	input logic signed [32:0] off_x,
	input logic signed [32:0] off_y,
	input logic [31:0] delta,
	output rpm_pkg::coord_t out_x,
	output rpm_pkg::coord_t out_y
);
	localparam int N = (STAGES > rpm_pkg::MAX_STAGES) ? rpm_pkg::MAX_STAGES : STAGES;
	localparam int DW = rpm_pkg::DW;

	// Vectoring stages; delta rides along.
	rpm_pkg::coord_t vx_s [N+1];
	rpm_pkg::coord_t vy_s [N+1];
	logic [31:0] vz_s [N+1];
	logic [31:0] vd_s [N+1];
	rpm_pkg::coord_t rx_s [N+1];
	rpm_pkg::coord_t ry_s [N+1];
	logic signed [32:0] rt_s [N+1];

	rpm_pkg::coord_t x0, y0;
	always_comb begin
		x0 = DW'(off_x) <<< rpm_pkg::GUARD_BITS;
		y0 = DW'(off_y) <<< rpm_pkg::GUARD_BITS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (x0 < 0) begin
				vx_s[0] <= -x0;
				vy_s[0] <= -y0;
				vz_s[0] <= rpm_pkg::HALF_TURN;
			end else begin
				vx_s[0] <= x0;
				vy_s[0] <= y0;
				vz_s[0] <= '0;
			end
			vd_s[0] <= delta;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (en) begin
				if (vy_s[i] >= 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + rpm_pkg::atan_turn(i);
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - rpm_pkg::atan_turn(i);
				end
				vd_s[i+1] <= vd_s[i];
			end
		end
	end

	logic [31:0] th;
	logic signed [32:0] ts;
	always_comb begin
		th = vz_s[N] + vd_s[N];
		ts = 33'(signed'(th));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ts > 33'sd1073741824) begin
				rx_s[0] <= -vx_s[N];
				rt_s[0] <= ts - 33'sd2147483648;
			end else if (ts < -33'sd1073741824) begin
				rx_s[0] <= -vx_s[N];
				rt_s[0] <= ts + 33'sd2147483647 + 33'sd1;
			end else begin
				rx_s[0] <= vx_s[N];
				rt_s[0] <= ts;
			end
			ry_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (en) begin
				if (rt_s[i] >= 0) begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					rt_s[i+1] <= rt_s[i] - 33'(rpm_pkg::atan_turn(i));
				end else begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					rt_s[i+1] <= rt_s[i] + 33'(rpm_pkg::atan_turn(i));
				end
			end
		end
	end

	assign out_x = rx_s[N];
	assign out_y = ry_s[N];
endmodule

// File: sv/rpm_gain.sv
module rpm_gain (
	input logic clk,
	input logic en,
	input rpm_pkg::coord_t v,
	output rpm_pkg::coord_t p
);
	localparam int DW = rpm_pkg::DW;
	logic neg_s1, neg_s2;
	logic [DW-1:0] mag;
	logic [DW-33:0] hi_s1;
	logic [31:0] lo_s1;
	logic [DW-1:0] phi_s2;
	logic [63:0] plo_s2;
	logic [DW-1:0] sum;

	assign mag = v[DW-1] ? DW'(-v) : DW'(v);

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= v[DW-1];
			hi_s1 <= mag[DW-1:32];
			lo_s1 <= mag[31:0];
			neg_s2 <= neg_s1;
			phi_s2 <= DW'(hi_s1) * DW'(rpm_pkg::INV_GAIN_SQ_Q32);
			plo_s2 <= 64'(lo_s1) * 64'(rpm_pkg::INV_GAIN_SQ_Q32);
		end
	end

	assign sum = phi_s2 + DW'((plo_s2 + 64'h8000_0000) >> 32);
	assign p = neg_s2 ? -signed'(sum) : signed'(sum);
endmodule

// File: sv/rpm_merge.sv
module rpm_merge (
	input logic clk,
	input logic en,
	input logic signed [31:0] cx,
	input logic signed [31:0] cy,
	input rpm_pkg::coord_t ax,
	input rpm_pkg::coord_t ay,
	input rpm_pkg::coord_t bx,
	input rpm_pkg::coord_t by,
	output logic signed [31:0] dx,
	output logic signed [31:0] dy,
	output logic sat
);
	localparam int DW = rpm_pkg::DW;
	localparam int G = rpm_pkg::GUARD_BITS;
	rpm_pkg::coord_t sx, sy, qx, qy;
	logic ox, oy, ux, uy;

	always_comb begin
		sx = (DW'(cx) <<< (G + 1)) + ax + bx + (DW'(1) <<< G);
		sy = (DW'(cy) <<< (G + 1)) + ay + by + (DW'(1) <<< G);
		qx = sx >>> (G + 1);
		qy = sy >>> (G + 1);
		ox = qx > DW'(32'sh7FFF_FFFF);
		ux = qx < -(DW'(1) <<< 31);
		oy = qy > DW'(32'sh7FFF_FFFF);
		uy = qy < -(DW'(1) <<< 31);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx <= ox ? 32'sh7FFF_FFFF : (ux ? 32'sh8000_0000 : qx[31:0]);
			dy <= oy ? 32'sh7FFF_FFFF : (uy ? 32'sh8000_0000 : qy[31:0]);
			sat <= ox | ux | oy | uy;
		end
	end
endmodule
